// File: rtl/ppp_pkg.sv
// Shared constants, register codes, status codes and stage control type for pinhole projection.
package ppp_pkg;

  localparam int MAX_SIDE_DEF  = 4096;
  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W    = 32;
  localparam int DEPTH_W    = 31;
  localparam int FOCAL_W    = 32;
  localparam int CENTER_W   = 28;
  localparam int SIZE_W     = 13;
  localparam int SIZE_MAX   = (1 << SIZE_W) - 1;
  localparam int PIX_W      = 12;
  localparam int PROD_W     = COORD_W + FOCAL_W;
  localparam int OFF_W      = DEPTH_W + CENTER_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [FOCAL_W-1:0]  FOCAL_X_RST      = 32'd34406400;
  localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST      = 32'd34406400;
  localparam logic [CENTER_W-1:0] CENTER_X_RST     = 28'd20938752;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST     = 28'd15695872;
  localparam logic [SIZE_W-1:0]   IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0]   IMAGE_HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X      = 3'd0,
    CFG_FOCAL_Y      = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_IMAGE_WIDTH  = 3'd4,
    CFG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_INVALID = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  typedef struct packed {
    logic valid;
    logic bad;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

// File: rtl/ppp_front.sv
// Front pipeline: input register, focal and offset products, signed numerator fold.
module ppp_front #(
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
  parameter int QBITS     = 12,
  parameter int CW        = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_z_i,
  input  logic                              point_ok_i,
  input  logic [ppp_pkg::FOCAL_W-1:0]       focal_x_i,
  input  logic [ppp_pkg::FOCAL_W-1:0]       focal_y_i,
  input  logic [ppp_pkg::CENTER_W-1:0]      center_x_i,
  input  logic [ppp_pkg::CENTER_W-1:0]      center_y_i,
  output ppp_pkg::ctl_t                     ctl_o,
  output logic [CW-1:0]                     div_o,
  output logic [CW-1:0]                     rem_x_o,
  output logic [CW-1:0]                     rem_y_o
);
  import ppp_pkg::*;

  // Turns sign and the two products into a magnitude and a sign of p*f + c*z.
  function automatic logic [PROD_W:0] fold(input logic neg, input logic [PROD_W-1:0] prod,
                                           input logic [OFF_W-1:0] off);
    logic [PROD_W-1:0] off_w;
    logic [PROD_W:0]   res;
    off_w = PROD_W'(off);
    if (!neg) begin
      res = {1'b0, prod + off_w};
    end else if (off_w >= prod) begin
      res = {1'b0, off_w - prod};
    end else begin
      res = {1'b1, prod - off_w};
    end
    return res;
  endfunction

  // Stage 1: magnitudes and flags.
  logic               s1_vld_q, s1_bad_q, s1_negx_q, s1_negy_q;
  logic [COORD_W-1:0] s1_magx_q, s1_magy_q;
  logic [DEPTH_W-1:0] s1_z_q;

  // Stage 2: products.
  logic               s2_vld_q, s2_bad_q, s2_negx_q, s2_negy_q;
  logic [PROD_W-1:0]  s2_prodx_q, s2_prody_q;
  logic [OFF_W-1:0]   s2_offx_q, s2_offy_q;
  logic [DEPTH_W-1:0] s2_z_q;

  logic [PROD_W:0]    fold_x, fold_y;
  ppp_pkg::ctl_t      ctl_d, ctl_q;
  logic [CW-1:0]      div_q, remx_q, remy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      ctl_q    <= '0;
    end else begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      ctl_q    <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_bad_q   <= !point_ok_i || point_z_i[COORD_W-1] || (point_z_i == '0);
    s1_negx_q  <= point_x_i[COORD_W-1];
    s1_negy_q  <= point_y_i[COORD_W-1];
    s1_magx_q  <= point_x_i[COORD_W-1] ? COORD_W'(-point_x_i) : COORD_W'(point_x_i);
    s1_magy_q  <= point_y_i[COORD_W-1] ? COORD_W'(-point_y_i) : COORD_W'(point_y_i);
    s1_z_q     <= point_z_i[DEPTH_W-1:0];

    s2_bad_q   <= s1_bad_q;
    s2_negx_q  <= s1_negx_q;
    s2_negy_q  <= s1_negy_q;
    s2_prodx_q <= PROD_W'(s1_magx_q) * PROD_W'(focal_x_i);
    s2_prody_q <= PROD_W'(s1_magy_q) * PROD_W'(focal_y_i);
    s2_offx_q  <= OFF_W'(s1_z_q) * OFF_W'(center_x_i);
    s2_offy_q  <= OFF_W'(s1_z_q) * OFF_W'(center_y_i);
    s2_z_q     <= s1_z_q;

    div_q      <= CW'(s2_z_q) << (FRAC_BITS + QBITS);
    remx_q     <= CW'(fold_x[PROD_W-1:0]);
    remy_q     <= CW'(fold_y[PROD_W-1:0]);
  end

  always_comb begin
    fold_x      = fold(s2_negx_q, s2_prodx_q, s2_offx_q);
    fold_y      = fold(s2_negy_q, s2_prody_q, s2_offy_q);
    ctl_d.valid = s2_vld_q;
    ctl_d.bad   = s2_bad_q;
    ctl_d.neg_x = fold_x[PROD_W];
    ctl_d.neg_y = fold_y[PROD_W];
  end

  assign ctl_o   = ctl_q;
  assign div_o   = div_q;
  assign rem_x_o = remx_q;
  assign rem_y_o = remy_q;

endmodule

// File: rtl/ppp_cell.sv
// One restoring-division cell: a quotient bit for each axis, divisor halved for the next cell.
module ppp_cell #(
  parameter int CW = 64,
  parameter int QW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppp_pkg::ctl_t ctl_i,
  input  logic [CW-1:0] div_i,
  input  logic [CW-1:0] rem_x_i,
  input  logic [CW-1:0] rem_y_i,
  input  logic [QW-1:0] q_x_i,
  input  logic [QW-1:0] q_y_i,
  output ppp_pkg::ctl_t ctl_o,
  output logic [CW-1:0] div_o,
  output logic [CW-1:0] rem_x_o,
  output logic [CW-1:0] rem_y_o,
  output logic [QW-1:0] q_x_o,
  output logic [QW-1:0] q_y_o
);
  import ppp_pkg::*;

  logic          ge_x, ge_y;
  ctl_t          ctl_q;
  logic [CW-1:0] div_q, remx_q, remy_q;
  logic [QW-1:0] qx_q, qy_q;

  assign ge_x = (rem_x_i >= div_i);
  assign ge_y = (rem_y_i >= div_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_i >> 1;
    remx_q <= ge_x ? (rem_x_i - div_i) : rem_x_i;
    remy_q <= ge_y ? (rem_y_i - div_i) : rem_y_i;
    qx_q   <= {q_x_i[QW-2:0], ge_x};
    qy_q   <= {q_y_i[QW-2:0], ge_y};
  end

  assign ctl_o   = ctl_q;
  assign div_o   = div_q;
  assign rem_x_o = remx_q;
  assign rem_y_o = remy_q;
  assign q_x_o   = qx_q;
  assign q_y_o   = qy_q;

endmodule

// File: rtl/pinhole_point_projection_core.sv
// Top level of the pinhole projection core: config registers, cell chain and result stage.
//
// Projects one camera-frame point (signed Q16.16 x, y, z and an ok flag) onto the image:
// column = trunc(x*fx/z + cx), row = trunc(y*fy/z + cy), then checks both against the
// image size. Status is hit, invalid point (ok low or z not positive) or outside.
//
// Input channel: a point beat is taken at every rising edge with start_i high. busy_o
// stays low, so a new point can be given in every cycle with no gaps.
// Result channel: done_o is high for one cycle with pixel_col_o, pixel_row_o and
// status_o. The receiver cannot stall, so every result is taken in that cycle.
// QBITS is the log2 of the image side limit. Throughput is one point per cycle: the
// division runs as a chain of QBITS + 1 cells, one quotient bit per cell, with three
// stages (input, multiply, fold) ahead of it and one result register.
// Config: a write beat on cfg_valid_i/cfg_ready_o sets the register at cfg_index_i;
// cfg_ready_o is always high and unknown indexes are dropped. Write only while idle.
// Reset loads the default camera (525 focal, 319.5/239.5 center, 640x480) and clears
// all pipeline valid flags; no point is in flight after reset.
module pinhole_point_projection_core #(
  parameter int MAX_SIDE  = ppp_pkg::MAX_SIDE_DEF,
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [ppp_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [ppp_pkg::COORD_W-1:0]  point_y_i,
  input  logic signed [ppp_pkg::COORD_W-1:0]  point_z_i,
  input  logic                                point_ok_i,
  output logic                                done_o,
  output logic [ppp_pkg::PIX_W-1:0]           pixel_col_o,
  output logic [ppp_pkg::PIX_W-1:0]           pixel_row_o,
  output logic [1:0]                          status_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ppp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ppp_pkg::*;

  localparam int LIM_MAX = (MAX_SIDE < SIZE_MAX) ? MAX_SIDE : SIZE_MAX;
  localparam int QBITS   = $clog2(LIM_MAX);
  localparam int QW      = QBITS + 1;
  localparam int NCELL   = QW;
  localparam int DIV_W   = DEPTH_W + FRAC_BITS + QBITS;
  localparam int CW      = (DIV_W > PROD_W) ? DIV_W : PROD_W;

  logic [FOCAL_W-1:0]  focal_x_q, focal_y_q;
  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [SIZE_W-1:0]   width_q, height_q;

  ctl_t          ctl_s   [NCELL+1];
  logic [CW-1:0] div_s   [NCELL+1];
  logic [CW-1:0] rem_x_s [NCELL+1];
  logic [CW-1:0] rem_y_s [NCELL+1];
  logic [QW-1:0] q_x_s   [NCELL+1];
  logic [QW-1:0] q_y_s   [NCELL+1];

  logic [QW-1:0]    lim_x, lim_y;
  logic [QBITS-1:0] qx_lo, qy_lo;
  logic             in_x, in_y;
  status_e          status_d, status_q;
  logic [PIX_W-1:0] col_d, row_d, col_q, row_q;
  logic             done_q;
  logic             accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_X_RST;
      focal_y_q  <= FOCAL_Y_RST;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      width_q    <= IMAGE_WIDTH_RST;
      height_q   <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FOCAL_X:      focal_x_q  <= cfg_data_i[FOCAL_W-1:0];
        CFG_FOCAL_Y:      focal_y_q  <= cfg_data_i[FOCAL_W-1:0];
        CFG_CENTER_X:     center_x_q <= cfg_data_i[CENTER_W-1:0];
        CFG_CENTER_Y:     center_y_q <= cfg_data_i[CENTER_W-1:0];
        CFG_IMAGE_WIDTH:  width_q    <= cfg_data_i[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: height_q   <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  ppp_front #(
    .FRAC_BITS (FRAC_BITS),
    .QBITS     (QBITS),
    .CW        (CW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .point_ok_i (point_ok_i),
    .focal_x_i  (focal_x_q),
    .focal_y_i  (focal_y_q),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .ctl_o      (ctl_s[0]),
    .div_o      (div_s[0]),
    .rem_x_o    (rem_x_s[0]),
    .rem_y_o    (rem_y_s[0])
  );

  assign q_x_s[0] = '0;
  assign q_y_s[0] = '0;

  // The first cell tests against z << QBITS; its bit marks a quotient beyond the image.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ppp_cell #(
      .CW (CW),
      .QW (QW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_s[i]),
      .div_i   (div_s[i]),
      .rem_x_i (rem_x_s[i]),
      .rem_y_i (rem_y_s[i]),
      .q_x_i   (q_x_s[i]),
      .q_y_i   (q_y_s[i]),
      .ctl_o   (ctl_s[i+1]),
      .div_o   (div_s[i+1]),
      .rem_x_o (rem_x_s[i+1]),
      .rem_y_o (rem_y_s[i+1]),
      .q_x_o   (q_x_s[i+1]),
      .q_y_o   (q_y_s[i+1])
    );
  end

  always_comb begin
    lim_x = (32'(width_q) > 32'(MAX_SIDE)) ? QW'(MAX_SIDE) : QW'(width_q);
    lim_y = (32'(height_q) > 32'(MAX_SIDE)) ? QW'(MAX_SIDE) : QW'(height_q);
    qx_lo = q_x_s[NCELL][QBITS-1:0];
    qy_lo = q_y_s[NCELL][QBITS-1:0];
    // A negative numerator lands on pixel 0 only when its magnitude is below one.
    in_x  = !q_x_s[NCELL][QBITS] && (!ctl_s[NCELL].neg_x || (qx_lo == '0)) &&
            ({1'b0, qx_lo} < lim_x);
    in_y  = !q_y_s[NCELL][QBITS] && (!ctl_s[NCELL].neg_y || (qy_lo == '0)) &&
            ({1'b0, qy_lo} < lim_y);
    if (ctl_s[NCELL].bad) begin
      status_d = ST_INVALID;
    end else if (in_x && in_y) begin
      status_d = ST_HIT;
    end else begin
      status_d = ST_OUTSIDE;
    end
    col_d = (status_d == ST_HIT) ? PIX_W'(qx_lo) : '0;
    row_d = (status_d == ST_HIT) ? PIX_W'(qy_lo) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_s[NCELL].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    col_q    <= col_d;
    row_q    <= row_d;
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign pixel_col_o = col_q;
  assign pixel_row_o = row_q;

  a_done_follows_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(ctl_s[NCELL].valid))
    else $error("result strobe does not follow the last cell");

  a_miss_zero_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_HIT)) |-> ((pixel_col_o == '0) && (pixel_row_o == '0)))
    else $error("pixels not cleared on a non-hit result");

  a_bad_is_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_s[NCELL].valid && ctl_s[NCELL].bad) |=> (done_o && (status_o == ST_INVALID)))
    else $error("invalid point not reported as invalid");

endmodule
